### sv/bpa_pkg.sv
// Package for the buddy page allocator: sizes, codes and descriptor types.
// No dependencies; used by every other file of the block except bpa_if.
`timescale 1ns / 1ps
package bpa_pkg;
  localparam int PAGES = 1024;
  localparam int LEVEL_COUNT = 11;
  localparam int PW = $clog2(PAGES);
  localparam int LW = $clog2(LEVEL_COUNT + 1);
  localparam int CW = PW + 1;
  localparam int TW = 16;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE = 1'b1;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOMEM = 2'd1;
  localparam logic [1:0] ST_BADREL = 2'd2;

  localparam logic [0:0] REG_PAGE_COUNT = 1'b0;

  // One page descriptor as held in the descriptor memory
  typedef struct packed {
    logic [PW-1:0] prev;
    logic prev_v;
    logic [PW-1:0] next;
    logic next_v;
    logic [3:0] lvl;
    logic used;
  } desc_t;

  // Request from the sequencer to the descriptor store
  typedef struct packed {
    logic rd;
    logic wr;
    logic [PW-1:0] addr;
    desc_t wdata;
  } dreq_t;
endpackage

### sv/bpa_if.sv
// Valid/ready channel interfaces for the allocator's items.
// No dependencies.
`timescale 1ns / 1ps
interface bpa_in_if;
  logic valid;
  logic ready;
  logic operation;
  logic [3:0] order;
  logic [9:0] page_index;
  logic [15:0] tag_in;
  modport source(output valid, operation, order, page_index, tag_in, input ready);
  modport sink(input valid, operation, order, page_index, tag_in, output ready);
endinterface

interface bpa_out_if;
  logic valid;
  logic ready;
  logic [1:0] status;
  logic [9:0] block_page;
  logic [15:0] tag_out;
  modport source(output valid, status, block_page, tag_out, input ready);
  modport sink(input valid, status, block_page, tag_out, output ready);
endinterface

### sv/bpa_desc_mem.sv
// Descriptor store: links, level and in-use bit per page, one port with a
// registered read. After reset a clearing pass marks every page in use and
// clears its links; busy is high meanwhile. Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_desc_mem (
  input  logic             clk,
  input  logic             rst_n,
  input  bpa_pkg::dreq_t   req,
  output bpa_pkg::desc_t   rdata,
  output logic             busy
);
  import bpa_pkg::*;

  desc_t mem [PAGES];
  logic [CW-1:0] clr_r;
  desc_t init_d;

  always_comb begin
    init_d = '0;
    init_d.used = 1'b1;
  end

  // clearing pass counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
    end else if (clr_r != CW'(PAGES)) begin
      clr_r <= clr_r + 1'b1;
    end
  end
  assign busy = (clr_r != CW'(PAGES));

  // single port memory, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_r[PW-1:0]] <= init_d;
    end else if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.addr];
    end
  end
endmodule

### sv/bpa_seq.sv
// Allocate/release sequencer: walks splits and merges through the descriptor
// store, at most one memory access per cycle. Depends on bpa_pkg.
`timescale 1ns / 1ps
module bpa_seq (
  input  logic                  clk,
  input  logic                  rst_n,
  bpa_in_if.sink                in_ch,
  bpa_out_if.source             out_ch,
  input  logic [bpa_pkg::CW-1:0] page_count,
  input  logic                  mem_busy,
  output bpa_pkg::dreq_t        req,
  input  bpa_pkg::desc_t        rdata
);
  import bpa_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_SCAN,
    // unlink n_r: read it, fix predecessor, fix successor
    S_UL_RD, S_UL_WT, S_UL_P0, S_UL_P1, S_UL_N0, S_UL_N1, S_UL_END,
    // push cur_r onto lvl_r: fix old head, then rewrite cur_r
    S_PU_H0, S_PU_H1, S_PU_N0, S_PU_N1,
    S_AL_FIN,
    S_RL_RD, S_RL_WT, S_RL_CHK, S_BD_RD, S_BD_WT,
    S_MG_LO0, S_MG_LO1, S_MG_HI0, S_MG_HI1,
    S_OUT
  } st_t;

  typedef enum logic [2:0] {
    R_SPLIT, R_SPLIT_LO, R_SPLIT_HI, R_ALLOC, R_MERGE, R_DONE
  } ret_t;

  st_t st_r;
  ret_t ret_r;
  logic [PW-1:0] head_r [LEVEL_COUNT];
  logic [LEVEL_COUNT-1:0] hv_r;
  logic [TW-1:0] tag_r [PAGES];
  logic [TW-1:0] tag_q_r;
  logic [TW-1:0] tag_out_r;

  logic [3:0] ord_r, j_r, lvl_r;
  logic [PW-1:0] pg_r, n_r, cur_r, bud_r;
  logic [TW-1:0] tagin_r;
  desc_t d_r;
  logic [1:0] status_r;
  logic [PW-1:0] bpage_r;
  logic ovalid_r;
  logic set_lvl_r, clr_used_r;
  logic bud_ok;
  logic [PW-1:0] pg_lo, pg_hi;

  // upper half of the block being split
  logic [PW-1:0] hi_r;
  logic hi_ok_r;
  logic [CW-1:0] hi_sum;

  assign in_ch.ready = (st_r == S_IDLE) && !mem_busy && !ovalid_r;
  assign out_ch.valid = ovalid_r;
  assign out_ch.status = status_r;
  assign out_ch.block_page = bpage_r;
  assign out_ch.tag_out = tag_out_r;

  assign hi_sum = {1'b0, n_r} + (CW'(1) << (j_r - 4'd1));
  assign pg_lo = (cur_r < bud_r) ? cur_r : bud_r;
  assign pg_hi = (cur_r < bud_r) ? bud_r : cur_r;

  // memory request decode
  always_comb begin
    req = '0;
    case (st_r)
      S_UL_RD: begin req.rd = 1'b1; req.addr = n_r; end
      S_RL_RD: begin req.rd = 1'b1; req.addr = pg_r; end
      S_BD_RD: begin req.rd = 1'b1; req.addr = bud_r; end
      S_UL_P0: begin req.rd = d_r.prev_v; req.addr = d_r.prev; end
      S_UL_P1: begin
        req.wr = 1'b1;
        req.addr = d_r.prev;
        req.wdata = rdata;
        req.wdata.next = d_r.next;
        req.wdata.next_v = d_r.next_v;
      end
      S_UL_N0: begin req.rd = d_r.next_v; req.addr = d_r.next; end
      S_UL_N1: begin
        req.wr = 1'b1;
        req.addr = d_r.next;
        req.wdata = rdata;
        req.wdata.prev = d_r.prev;
        req.wdata.prev_v = d_r.prev_v;
      end
      S_PU_H0: begin req.rd = hv_r[lvl_r]; req.addr = head_r[lvl_r]; end
      S_PU_H1: begin
        req.wr = 1'b1;
        req.addr = head_r[lvl_r];
        req.wdata = rdata;
        req.wdata.prev = cur_r;
        req.wdata.prev_v = 1'b1;
      end
      S_PU_N0: begin req.rd = 1'b1; req.addr = cur_r; end
      S_PU_N1: begin
        req.wr = 1'b1;
        req.addr = cur_r;
        req.wdata = rdata;
        req.wdata.prev = '0;
        req.wdata.prev_v = 1'b0;
        req.wdata.next = head_r[lvl_r];
        req.wdata.next_v = hv_r[lvl_r];
        if (set_lvl_r) req.wdata.lvl = lvl_r;
        if (clr_used_r) req.wdata.used = 1'b0;
      end
      S_AL_FIN: begin
        req.wr = 1'b1;
        req.addr = n_r;
        req.wdata = d_r;
        req.wdata.used = 1'b1;
      end
      S_RL_WT: begin
        req.wr = rdata.used;
        req.addr = pg_r;
        req.wdata = rdata;
        req.wdata.used = 1'b0;
      end
      S_MG_LO0: begin req.rd = 1'b1; req.addr = pg_lo; end
      S_MG_LO1: begin
        req.wr = 1'b1;
        req.addr = pg_lo;
        req.wdata = rdata;
        req.wdata.lvl = lvl_r + 4'd1;
      end
      S_MG_HI0: begin req.rd = 1'b1; req.addr = pg_hi; end
      S_MG_HI1: begin
        req.wr = 1'b1;
        req.addr = pg_hi;
        req.wdata = rdata;
        req.wdata.used = 1'b1;
      end
      default: ;
    endcase
  end

  // buddy merge check
  always_comb begin
    bud_ok = (CW'(bud_r) < page_count) && !rdata.used && (rdata.lvl == lvl_r);
  end

  // tag memory, registered read
  always_ff @(posedge clk) begin
    if (st_r == S_AL_FIN) begin
      tag_r[n_r] <= tagin_r;
    end
    if (st_r == S_RL_RD) begin
      tag_q_r <= tag_r[pg_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      hv_r <= '0;
      ovalid_r <= 1'b0;
      ret_r <= R_DONE;
    end else begin
      if (st_r == S_OUT) begin
        ovalid_r <= 1'b1;
      end else if (ovalid_r && out_ch.ready) begin
        ovalid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: if (in_ch.valid && in_ch.ready) begin
          ord_r <= in_ch.order;
          j_r <= in_ch.order;
          pg_r <= in_ch.page_index;
          tagin_r <= in_ch.tag_in;
          tag_out_r <= '0;
          bpage_r <= (in_ch.operation == OP_FREE) ? in_ch.page_index : '0;
          if (in_ch.operation == OP_ALLOC) begin
            if (32'(in_ch.order) >= LEVEL_COUNT) begin
              status_r <= ST_NOMEM;
              st_r <= S_OUT;
            end else begin
              status_r <= ST_OK;
              st_r <= S_SCAN;
            end
          end else if (CW'(in_ch.page_index) >= page_count) begin
            status_r <= ST_BADREL;
            st_r <= S_OUT;
          end else begin
            status_r <= ST_OK;
            st_r <= S_RL_RD;
          end
        end
        // find first non-empty level, one level per cycle
        S_SCAN: begin
          if (32'(j_r) >= LEVEL_COUNT) begin
            status_r <= ST_NOMEM;
            st_r <= S_OUT;
          end else if (hv_r[j_r]) begin
            n_r <= head_r[j_r];
            ret_r <= (j_r == ord_r) ? R_ALLOC : R_SPLIT;
            st_r <= S_UL_RD;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        // unlink n_r
        S_UL_RD: st_r <= S_UL_WT;
        S_UL_WT: begin
          d_r <= rdata;
          st_r <= S_UL_P0;
        end
        S_UL_P0: begin
          if (32'(d_r.lvl) < LEVEL_COUNT && hv_r[d_r.lvl] && head_r[d_r.lvl] == n_r) begin
            head_r[d_r.lvl] <= d_r.next;
            hv_r[d_r.lvl] <= d_r.next_v;
          end
          st_r <= d_r.prev_v ? S_UL_P1 : S_UL_N0;
        end
        S_UL_P1: st_r <= S_UL_N0;
        S_UL_N0: st_r <= d_r.next_v ? S_UL_N1 : S_UL_END;
        S_UL_N1: st_r <= S_UL_END;
        S_UL_END: begin
          case (ret_r)
            R_ALLOC: st_r <= S_AL_FIN;
            R_SPLIT: begin
              lvl_r <= j_r - 4'd1;
              cur_r <= n_r;
              hi_r <= hi_sum[PW-1:0];
              hi_ok_r <= (hi_sum < CW'(PAGES));
              set_lvl_r <= 1'b1;
              clr_used_r <= 1'b0;
              ret_r <= R_SPLIT_LO;
              st_r <= S_PU_H0;
            end
            R_MERGE: st_r <= S_MG_LO0;
            default: st_r <= S_IDLE;
          endcase
        end
        // push cur_r onto lvl_r
        S_PU_H0: st_r <= hv_r[lvl_r] ? S_PU_H1 : S_PU_N0;
        S_PU_H1: st_r <= S_PU_N0;
        S_PU_N0: st_r <= S_PU_N1;
        S_PU_N1: begin
          head_r[lvl_r] <= cur_r;
          hv_r[lvl_r] <= 1'b1;
          case (ret_r)
            R_SPLIT_LO: begin
              if (hi_ok_r) begin
                cur_r <= hi_r;
                clr_used_r <= 1'b1;
                ret_r <= R_SPLIT_HI;
                st_r <= S_PU_H0;
              end else begin
                j_r <= lvl_r;
                st_r <= S_SCAN;
              end
            end
            R_SPLIT_HI: begin
              j_r <= lvl_r;
              st_r <= S_SCAN;
            end
            default: st_r <= S_OUT;
          endcase
        end
        S_AL_FIN: begin
          bpage_r <= n_r;
          st_r <= S_OUT;
        end
        // release: check in use, clear it, then walk merges
        S_RL_RD: st_r <= S_RL_WT;
        S_RL_WT: begin
          if (!rdata.used) begin
            status_r <= ST_BADREL;
            st_r <= S_OUT;
          end else begin
            tag_out_r <= tag_q_r;
            cur_r <= pg_r;
            lvl_r <= rdata.lvl;
            st_r <= S_RL_CHK;
          end
        end
        S_RL_CHK: begin
          if (32'(lvl_r) + 1 < LEVEL_COUNT) begin
            bud_r <= cur_r ^ (PW'(1) << lvl_r);
            st_r <= S_BD_RD;
          end else begin
            set_lvl_r <= 1'b0;
            clr_used_r <= 1'b0;
            ret_r <= R_DONE;
            st_r <= S_PU_H0;
          end
        end
        S_BD_RD: st_r <= S_BD_WT;
        S_BD_WT: begin
          if (bud_ok) begin
            d_r <= rdata;
            n_r <= bud_r;
            ret_r <= R_MERGE;
            st_r <= S_UL_P0;
          end else begin
            set_lvl_r <= 1'b0;
            clr_used_r <= 1'b0;
            ret_r <= R_DONE;
            st_r <= S_PU_H0;
          end
        end
        // merged block: lower page gets the next level, upper page reads used
        S_MG_LO0: st_r <= S_MG_LO1;
        S_MG_LO1: st_r <= S_MG_HI0;
        S_MG_HI0: st_r <= S_MG_HI1;
        S_MG_HI1: begin
          cur_r <= pg_lo;
          lvl_r <= lvl_r + 4'd1;
          st_r <= S_RL_CHK;
        end
        S_OUT: st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_OUT) |=> ovalid_r) else $error("result not raised");
  assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> (st_r == S_IDLE)) else $error("ready while busy");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> ovalid_r) else $error("result dropped");
  assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && !out_ch.ready) |=> $stable({status_r, bpage_r, tag_out_r}))
    else $error("result changed while waiting");
endmodule

### sv/buddy_page_allocator_core.sv
// Buddy page allocator: one item at a time. A request refused at decode passes
// through S_OUT before its result is raised; an allocate that splits down
// through every level or a release that merges up through them takes longest,
// set by the split/merge walk through the single-port descriptor memory (a
// read and a write per descriptor update, several per level). Ready stays low
// until the result has been taken. After reset a clearing pass holds ready
// low. Depends on bpa_pkg, bpa_if, bpa_desc_mem, bpa_seq.
`timescale 1ns / 1ps
module buddy_page_allocator_core (
  input  logic        clk,
  input  logic        rst_n,
  bpa_in_if.sink      in_ch,
  bpa_out_if.source   out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [0:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import bpa_pkg::*;

  logic [CW-1:0] pc_r;
  dreq_t req;
  desc_t rdata;
  logic busy;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == REG_PAGE_COUNT) ? 32'(pc_r) : '0;

  // page_count register, saturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= CW'(PAGES);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == REG_PAGE_COUNT) begin
      pc_r <= (cfg_pwdata[CW-1:0] > CW'(PAGES)) ? CW'(PAGES) : cfg_pwdata[CW-1:0];
    end
  end

  bpa_desc_mem u_mem (.clk, .rst_n, .req, .rdata, .busy);
  bpa_seq u_seq (.clk, .rst_n, .in_ch, .out_ch, .page_count(pc_r),
    .mem_busy(busy), .req, .rdata);
endmodule

### dv/tb_top.sv
// Self-checking testbench for buddy_page_allocator_core: directed and random
// allocate/release items, checked against an in-bench allocator predictor.
// Depends on bpa_pkg, bpa_if and the allocator RTL.
`timescale 1ns / 1ps
module tb_top;
  import bpa_pkg::*;

  typedef struct packed {
    logic op;
    logic [3:0] order;
    logic [9:0] page;
    logic [15:0] tag;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [9:0] page;
    logic [15:0] tag;
    logic tag_known;
  } alloc_rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [0:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  bpa_in_if in_ch();
  bpa_out_if out_ch();

  buddy_page_allocator_core dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Predictor state: free lists, descriptor links and page flags
  int unsigned free_head[LEVEL_COUNT];
  bit head_v[LEVEL_COUNT];
  int unsigned prev_pg[PAGES], next_pg[PAGES];
  bit prev_v[PAGES], next_v[PAGES];
  int unsigned blk_lvl[PAGES];
  bit used[PAGES];
  logic [15:0] page_tag[PAGES];
  bit tag_set[PAGES];
  int unsigned page_limit;

  alloc_req_t pending_reqs[$];
  alloc_rsp_t expected_rsps[$];
  int unsigned live_blocks[$];
  int unsigned idle_pct = 0, stall_pct = 0;
  int errors = 0;
  longint cycles = 0;
  bit in_acc = 1'b0;

  function automatic void list_push(int unsigned lvl, int unsigned n);
    if (head_v[lvl]) begin
      prev_pg[free_head[lvl]] = n;
      prev_v[free_head[lvl]] = 1'b1;
    end
    prev_v[n] = 1'b0;
    prev_pg[n] = 0;
    next_pg[n] = free_head[lvl];
    next_v[n] = head_v[lvl];
    free_head[lvl] = n;
    head_v[lvl] = 1'b1;
  endfunction

  function automatic void list_unlink(int unsigned n);
    int unsigned lvl;
    lvl = blk_lvl[n];
    if (prev_v[n]) begin
      next_pg[prev_pg[n]] = next_pg[n];
      next_v[prev_pg[n]] = next_v[n];
    end
    if (next_v[n]) begin
      prev_pg[next_pg[n]] = prev_pg[n];
      prev_v[next_pg[n]] = prev_v[n];
    end
    if (lvl < LEVEL_COUNT && head_v[lvl] && free_head[lvl] == n) begin
      free_head[lvl] = next_pg[n];
      head_v[lvl] = next_v[n];
    end
  endfunction

  // Allocator behavior for one item; updates predictor state
  function automatic alloc_rsp_t predict_alloc(alloc_req_t r);
    alloc_rsp_t e;
    int unsigned j, lo, hi, got, cur, lvl, bud, lsb, msb;
    e = '0;
    e.tag_known = 1'b1;
    if (r.op == OP_ALLOC) begin
      if (r.order >= LEVEL_COUNT) begin
        e.status = ST_NOMEM;
        return e;
      end
      j = r.order;
      while (j < LEVEL_COUNT && !head_v[j]) j++;
      if (j >= LEVEL_COUNT) begin
        e.status = ST_NOMEM;
        return e;
      end
      // split down to the requested level; upper half ends up at the head
      while (j > r.order) begin
        lo = free_head[j];
        list_unlink(lo);
        blk_lvl[lo] = j - 1;
        hi = lo + (1 << (j - 1));
        list_push(j - 1, lo);
        if (hi < PAGES) begin
          used[hi] = 1'b0;
          blk_lvl[hi] = j - 1;
          list_push(j - 1, hi);
        end
        j--;
      end
      if (!head_v[r.order]) begin
        e.status = ST_NOMEM;
        return e;
      end
      got = free_head[r.order];
      list_unlink(got);
      used[got] = 1'b1;
      page_tag[got] = r.tag;
      tag_set[got] = 1'b1;
      e.page = 10'(got);
      return e;
    end
    e.page = r.page;
    if (r.page >= page_limit || !used[r.page]) begin
      e.status = ST_BADREL;
      return e;
    end
    e.tag = page_tag[r.page];
    e.tag_known = tag_set[r.page];
    used[r.page] = 1'b0;
    // merge with free buddies of the same level
    cur = r.page;
    forever begin
      lvl = blk_lvl[cur];
      if (lvl + 1 < LEVEL_COUNT) begin
        bud = cur ^ (1 << lvl);
        if (bud < page_limit && !used[bud] && blk_lvl[bud] == lvl) begin
          lsb = cur < bud ? cur : bud;
          msb = cur < bud ? bud : cur;
          list_unlink(bud);
          blk_lvl[lsb] = lvl + 1;
          used[msb] = 1'b1;
          cur = lsb;
          continue;
        end
      end
      list_push(lvl, cur);
      break;
    end
    return e;
  endfunction

  task automatic queue_item(logic op, int unsigned ord, int unsigned pg, int unsigned tg);
    alloc_req_t r;
    alloc_rsp_t e;
    r.op = op;
    r.order = 4'(ord);
    r.page = 10'(pg);
    r.tag = 16'(tg);
    e = predict_alloc(r);
    if (op == OP_ALLOC && e.status == ST_OK) live_blocks.push_back(e.page);
    pending_reqs.push_back(r);
    expected_rsps.push_back(e);
  endtask

  // Mostly releases of live blocks or in-use pages, allocations of small orders
  task automatic queue_random_item();
    int unsigned pick, pg, k;
    pick = $urandom_range(99);
    if (pick < 42) begin
      queue_item(OP_ALLOC, ($urandom_range(9) < 8) ? $urandom_range(3) : $urandom_range(15),
                 $urandom_range(1023), $urandom_range(16'hffff));
    end else if (pick < 65 && live_blocks.size() > 0) begin
      k = $urandom_range(live_blocks.size() - 1);
      pg = live_blocks[k];
      live_blocks.delete(k);
      queue_item(OP_FREE, $urandom_range(15), pg, $urandom_range(16'hffff));
    end else if (pick < 92) begin
      pg = $urandom_range(page_limit - 1);
      for (k = 0; k < 8 && !used[pg]; k++) pg = $urandom_range(page_limit - 1);
      queue_item(OP_FREE, $urandom_range(15), pg, $urandom_range(16'hffff));
    end else begin
      queue_item($urandom_range(1), $urandom_range(15), $urandom_range(1023),
                 $urandom_range(16'hffff));
    end
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk);
  endtask

  task automatic write_page_count(int unsigned value);
    wait_drained();
    repeat (250) @(posedge clk);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= REG_PAGE_COUNT;
    cfg_pwdata <= value;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    page_limit = ((value & 32'h7ff) > PAGES) ? PAGES : (value & 32'h7ff);
  endtask

  // Acceptance flag and cycle limit, sampled at the rising edge
  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Driver: next item at the falling edge, with random sender gaps
  always @(negedge clk) begin
    alloc_req_t r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_acc || !in_ch.valid) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
        r = pending_reqs.pop_front();
        in_ch.operation <= r.op;
        in_ch.order <= r.order;
        in_ch.page_index <= r.page;
        in_ch.tag_in <= r.tag;
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
    out_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // Monitor: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    alloc_rsp_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_rsps.size() == 0) begin
        $display("%0t: unexpected result status=%0d page=%0d tag=%h", $realtime,
                 out_ch.status, out_ch.block_page, out_ch.tag_out);
        errors++;
      end else begin
        e = expected_rsps.pop_front();
        if (out_ch.status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, out_ch.status);
          errors++;
        end
        if (out_ch.block_page !== e.page) begin
          $display("%0t: block_page expected %0d actual %0d", $realtime, e.page,
                   out_ch.block_page);
          errors++;
        end
        // tag of a page never tagged since reset is not defined
        if (e.tag_known && out_ch.tag_out !== e.tag) begin
          $display("%0t: tag_out expected %h actual %h", $realtime, e.tag, out_ch.tag_out);
          errors++;
        end
      end
    end
  end

  initial begin
    int unsigned limits[8] = '{1024, 64, 2047, 1, 200, 1024, 37, 1024};
    int unsigned idles[8] = '{0, 83, 0, 32, 83, 0, 32, 0};
    int unsigned stalls[8] = '{0, 0, 83, 32, 0, 83, 32, 0};
    in_ch.valid = 1'b0;
    in_ch.operation = OP_ALLOC;
    in_ch.order = '0;
    in_ch.page_index = '0;
    in_ch.tag_in = '0;
    out_ch.ready = 1'b0;
    page_limit = PAGES;
    for (int i = 0; i < PAGES; i++) begin
      used[i] = 1'b1;
      blk_lvl[i] = 0;
      tag_set[i] = 1'b0;
      page_tag[i] = '0;
      prev_v[i] = 1'b0;
      next_v[i] = 1'b0;
    end
    for (int i = 0; i < LEVEL_COUNT; i++) head_v[i] = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty lists, oversized orders, bad and double releases, merges
    queue_item(OP_ALLOC, 0, 0, 16'h0000);
    queue_item(OP_ALLOC, 15, 1023, 16'hffff);
    queue_item(OP_ALLOC, LEVEL_COUNT, 0, 16'h1234);
    queue_item(OP_FREE, 0, 1023, 0);
    queue_item(OP_FREE, 0, 1023, 0);
    queue_item(OP_FREE, 15, 1022, 16'hffff);
    queue_item(OP_FREE, 0, 1023, 0);
    queue_item(OP_ALLOC, 0, 0, 16'hffff);
    queue_item(OP_ALLOC, 1, 0, 16'ha5a5);
    queue_item(OP_ALLOC, 0, 0, 16'h5a5a);
    queue_item(OP_FREE, 0, 1023, 0);
    queue_item(OP_FREE, 0, 1022, 0);
    for (int i = 0; i < 8; i++) queue_item(OP_FREE, 0, i, 0);
    queue_item(OP_ALLOC, 3, 0, 16'h8001);
    queue_item(OP_ALLOC, 10, 0, 16'h0001);
    queue_item(OP_FREE, 0, 0, 0);

    // Random phases over page_count settings, idle patterns and output stalls
    for (int ph = 0; ph < 8; ph++) begin
      write_page_count(limits[ph]);
      idle_pct = idles[ph];
      stall_pct = stalls[ph];
      live_blocks.delete();
      repeat (90) queue_random_item();
      if (ph == 0) begin
        // sender holds off until the block has answered everything
        wait_drained();
        repeat (90) queue_random_item();
      end
    end

    wait_drained();
    repeat (250) @(posedge clk);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
